// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  // Number of entries the queue can hold.
  localparam int unsigned DEPTH = 16;

  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = PTR_W + 1;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned COUNT_W = 5;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_CONSUME = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic               func;
    logic [VALUE_W-1:0] item_value;
    logic [TAG_W-1:0]   item_tag;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic               out_valid;
    logic [VALUE_W-1:0] out_value;
    logic [TAG_W-1:0]   out_tag;
    logic [COUNT_W-1:0] queue_count;
    logic               rejected;
  } rsp_t;

endpackage

// ===== rtl/spq_if.sv =====
`timescale 1ns / 1ps

interface spq_req_if;
  import spq_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [VALUE_W-1:0] item_value;
  logic [TAG_W-1:0]   item_tag;

  modport source (output valid, output func, output item_value, output item_tag,
                  input ready);
  modport sink   (input valid, input func, input item_value, input item_tag,
                  output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;

  logic               valid;
  logic               ready;
  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic [TAG_W-1:0]   out_tag;
  logic [COUNT_W-1:0] queue_count;
  logic               rejected;

  modport source (output valid, output out_valid, output out_value, output out_tag,
                  output queue_count, output rejected, input ready);
  modport sink   (input valid, input out_valid, input out_value, input out_tag,
                  input queue_count, input rejected, output ready);
endinterface

// ===== rtl/spq_engine.sv =====
`timescale 1ns / 1ps

module spq_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  spq_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output spq_pkg::rsp_t res_o
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_PLACE,
    ST_DONE
  } state_e;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    ptr_t r;
    if (p == '0) begin
      r = PTR_W'(DEPTH - 1);
    end else begin
      r = p - 1'b1;
    end
    return r;
  endfunction

  function automatic ptr_t ptr_add(ptr_t base, cnt_t n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(n);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  state_e state_q, state_d;
  ptr_t   head_q, head_d;
  ptr_t   rd_ptr_q, rd_ptr_d;
  ptr_t   wr_ptr_q, wr_ptr_d;
  cnt_t   count_q, count_d;
  cnt_t   pos_q, pos_d;
  entry_t new_q, new_d;
  rsp_t   res_q, res_d;

  entry_t mem [DEPTH];
  entry_t rdata_q;
  logic   wr_en;
  ptr_t   wr_addr;
  entry_t wr_data;

  ptr_t   tail;
  cnt_t   count_inc;
  cnt_t   count_dec;
  rsp_t   res_insert_ok;

  assign tail      = ptr_add(head_q, count_q);
  assign count_inc = count_q + 1'b1;
  assign count_dec = count_q - 1'b1;

  assign res_insert_ok = '{out_valid: 1'b0, out_value: '0, out_tag: '0,
                           queue_count: COUNT_W'(count_inc), rejected: 1'b0};

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    pos_d    = pos_q;
    new_d    = new_q;
    res_d    = res_q;
    wr_en    = 1'b0;
    wr_addr  = wr_ptr_q;
    wr_data  = new_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_i.func == FUNC_INSERT) begin
            new_d = '{value: req_i.item_value, tag: req_i.item_tag};
            if (count_q == CNT_W'(DEPTH)) begin
              res_d = '{out_valid: 1'b0, out_value: '0, out_tag: '0,
                        queue_count: COUNT_W'(count_q), rejected: 1'b1};
              state_d = ST_DONE;
            end else if (count_q == '0) begin
              wr_en   = 1'b1;
              wr_addr = head_q;
              wr_data = '{value: req_i.item_value, tag: req_i.item_tag};
              count_d = count_inc;
              res_d   = res_insert_ok;
              state_d = ST_DONE;
            end else begin
              // Walk from the tail toward the head, moving each smaller or
              // equal entry one place back.
              pos_d    = count_q;
              wr_ptr_d = tail;
              rd_ptr_d = ptr_dec(tail);
              state_d  = ST_WALK;
            end
          end else begin
            if (count_q == '0) begin
              res_d = '{out_valid: 1'b0, out_value: '0, out_tag: '0,
                        queue_count: COUNT_W'(count_q), rejected: 1'b0};
              state_d = ST_DONE;
            end else begin
              rd_ptr_d = head_q;
              state_d  = ST_FETCH;
            end
          end
        end
      end

      ST_FETCH: begin
        res_d = '{out_valid: 1'b1, out_value: rdata_q.value, out_tag: rdata_q.tag,
                  queue_count: COUNT_W'(count_dec), rejected: 1'b0};
        head_d  = ptr_inc(head_q);
        count_d = count_dec;
        state_d = ST_DONE;
      end

      ST_WALK: begin
        wr_en   = 1'b1;
        wr_addr = wr_ptr_q;
        if (rdata_q.value > new_q.value) begin
          wr_data = new_q;
          count_d = count_inc;
          res_d   = res_insert_ok;
          state_d = ST_DONE;
        end else begin
          wr_data  = rdata_q;
          wr_ptr_d = rd_ptr_q;
          rd_ptr_d = ptr_dec(rd_ptr_q);
          pos_d    = pos_q - 1'b1;
          if (pos_q == CNT_W'(1)) begin
            state_d = ST_PLACE;
          end
        end
      end

      ST_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = wr_ptr_q;
        wr_data = new_q;
        count_d = count_inc;
        res_d   = res_insert_ok;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      pos_q    <= '0;
      new_q    <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      pos_q    <= pos_d;
      new_q    <= new_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_ptr_d];
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps

// Bounded priority queue of up to DEPTH entries (see spq_pkg), kept sorted by
// value with the highest value at the head. An insert transfer places its value
// and tag ahead of the first stored entry whose value is less than or equal to
// it, so among equal values the newest comes out first; an insert into a full
// queue is dropped and its result has rejected set. A consume transfer removes
// and returns the head entry, or returns out_valid low with zero value and tag
// when the queue is empty. Every request gives exactly one response transfer,
// and each response reports the occupancy after the request. The entries live
// in a single-port-write, single-port-read memory used as a ring, so a consume
// only advances the head pointer. An insert walks from the tail toward the head
// through the one read port, moving one entry per cycle; a walk starts with at
// most DEPTH - 1 stored entries, since an empty or full queue needs no walk.
// The queue takes one request at a time, but a finished response sits in an
// output register, so the next request is accepted while the previous response
// still waits for the sink. No clearing pass is needed after reset; only
// positions below the occupancy are ever read.
module sorted_priority_queue_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);
  import spq_pkg::*;

  req_t req;
  rsp_t eng_res;
  logic eng_res_valid;
  logic eng_res_take;
  logic eng_req_ready;

  rsp_t out_q;
  logic out_vld_q;

  assign req = '{func: req_i.func, item_value: req_i.item_value, item_tag: req_i.item_tag};

  // The engine hands its result over whenever the output register is empty or
  // is being emptied in this cycle.
  assign eng_res_take = eng_res_valid && (!out_vld_q || rsp_o.ready);

  spq_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (eng_req_ready),
    .req_i       (req),
    .res_valid_o (eng_res_valid),
    .res_ready_i (!out_vld_q || rsp_o.ready),
    .res_o       (eng_res)
  );

  assign req_i.ready = eng_req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (eng_res_take) begin
        out_vld_q <= 1'b1;
        out_q     <= eng_res;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.out_valid   = out_q.out_valid;
  assign rsp_o.out_value   = out_q.out_value;
  assign rsp_o.out_tag     = out_q.out_tag;
  assign rsp_o.queue_count = out_q.queue_count;
  assign rsp_o.rejected    = out_q.rejected;

  // A rejected insert can only happen when the queue is full.
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.rejected |-> rsp_o.queue_count == COUNT_W'(DEPTH))
    else $error("rejected response without a full queue");

  // A response without an entry carries zero value and tag.
  a_empty_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.out_valid |-> rsp_o.out_value == '0 && rsp_o.out_tag == '0)
    else $error("response without an entry carries a nonzero payload");

  // New requests are taken only once the engine has passed on its last result.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !eng_res_valid)
    else $error("request accepted while a result is still held in the engine");

  // A result handed over shows up on the response port in the next cycle.
  a_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_res_take |=> rsp_o.valid && out_q == $past(eng_res))
    else $error("result lost between engine and output register");

endmodule
